[sv/rfmu_pkg.sv]
// Shared types and constants for the recursive FIFO mutex unit.
package rfmu_pkg;

    localparam int THREAD_COUNT_DEF = 16;
    localparam int COUNT_WIDTH_DEF  = 16;
    localparam int TID_W            = 4;
    localparam int STATUS_W         = 3;
    localparam int S_TDATA_W        = 8;
    localparam int M_TDATA_W        = 16;

    typedef enum logic [1:0] {
        OP_LOCK    = 2'd0,
        OP_TRYLOCK = 2'd1,
        OP_UNLOCK  = 2'd2,
        OP_DESTROY = 2'd3
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK         = 3'd0,
        STAT_WAITING    = 3'd1,
        STAT_BUSY       = 3'd2,
        STAT_NOT_OWNER  = 3'd3,
        STAT_QUEUE_FULL = 3'd4,
        STAT_OVERFLOW   = 3'd5
    } status_t;

    typedef enum logic {
        FSM_IDLE = 1'b0,
        FSM_EXEC = 1'b1
    } fsm_t;

    // Queue commands from the lock logic to the waiter queue
    typedef struct packed {
        logic             push;
        logic             pop;
        logic             clear;
        logic [TID_W-1:0] push_id;
    } queue_cmd_t;

endpackage

[sv/recursive_fifo_mutex_unit_top.sv]
// Recursive mutex with FIFO hand-off: a transaction is accepted, then executed.
// The result is registered when the execute state fires, which waits while an earlier result
// is still held untaken; m_tvalid rises with it. No new transaction is accepted until the
// previous one has executed. A new transaction is taken while a result waits.
// Reset (aresetn low, synchronous) clears owner, hold count, queue pointers, count and the
// in-queue flags; the queue memory itself is not cleared and needs no clearing pass.
module recursive_fifo_mutex_unit_top
    import rfmu_pkg::*;
#(
    parameter int THREAD_COUNT = THREAD_COUNT_DEF,
    parameter int COUNT_WIDTH  = COUNT_WIDTH_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // [1:0] operation, [5:2] thread_id, [7:6] zero
    input  logic [S_TDATA_W-1:0] s_tdata,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // [2:0] status, [3] wake_valid, [7:4] wake_thread, [8] owner_valid,
    // [12:9] owner_thread, [15:13] zero
    output logic [M_TDATA_W-1:0] m_tdata
);

    localparam int PTR_W = $clog2(THREAD_COUNT);
    localparam int CNT_W = $clog2(THREAD_COUNT + 1);

    fsm_t state_reg, state_next;

    logic              s_fire, exec_fire;
    op_t               op_reg;
    logic [TID_W-1:0]  tid_reg;

    logic              held_reg, held_next;
    logic [TID_W-1:0]  owner_reg, owner_next;
    logic [COUNT_WIDTH-1:0] hold_reg, hold_next, hold_dec;
    logic [THREAD_COUNT-1:0] flags_reg, flags_next;

    queue_cmd_t        qcmd;
    logic [TID_W-1:0]  front_id;
    logic [CNT_W-1:0]  q_count;

    status_t           status;
    logic              wake_v;
    logic [TID_W-1:0]  wake_t;

    logic              own, in_range, q_empty, q_full, front_match;
    logic [PTR_W-1:0]  tid_idx;
    logic [11:0]       tid_wide;

    logic              m_valid_reg, m_valid_next;
    logic [M_TDATA_W-1:0] m_data_reg;

    rfmu_wait_queue #(
        .THREAD_COUNT(THREAD_COUNT)
    ) u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (qcmd),
        .front_id(front_id),
        .count   (q_count)
    );

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            FSM_IDLE: if (s_tvalid) state_next = FSM_EXEC;
            FSM_EXEC: if (exec_fire) state_next = FSM_IDLE;
            default:  state_next = FSM_IDLE;
        endcase
    end

    // FSM outputs
    always_comb begin
        s_tready  = 1'b0;
        exec_fire = 1'b0;
        case (state_reg)
            FSM_IDLE: s_tready  = 1'b1;
            FSM_EXEC: exec_fire = !m_valid_reg || m_tready;
            default:  s_tready  = 1'b0;
        endcase
    end

    assign s_fire = s_tvalid && s_tready;

    // Capture the transaction
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            op_reg  <= op_t'(s_tdata[1:0]);
            tid_reg <= s_tdata[5:2];
        end
    end

    assign tid_wide    = {8'd0, tid_reg};
    assign tid_idx     = tid_wide[PTR_W-1:0];
    assign in_range    = 32'(tid_reg) < THREAD_COUNT;
    assign own         = held_reg && (owner_reg == tid_reg);
    assign q_empty     = (q_count == '0);
    assign q_full      = (32'(q_count) >= THREAD_COUNT);
    assign front_match = !q_empty && (front_id == tid_reg);
    assign hold_dec    = (hold_reg == '0) ? '0 : hold_reg - COUNT_WIDTH'(1);

    // Lock decision
    always_comb begin
        held_next    = held_reg;
        owner_next   = owner_reg;
        hold_next    = hold_reg;
        flags_next   = flags_reg;
        qcmd         = '0;
        qcmd.push_id = tid_reg;
        status       = STAT_OK;
        wake_v       = 1'b0;
        wake_t       = '0;
        case (op_reg)
            OP_LOCK, OP_TRYLOCK: begin
                if (own) begin
                    if (hold_reg == '1) begin
                        status = STAT_OVERFLOW;
                    end else begin
                        hold_next = hold_reg + COUNT_WIDTH'(1);
                    end
                end else if (!held_reg && (q_empty || front_match)) begin
                    held_next  = 1'b1;
                    owner_next = tid_reg;
                    hold_next  = COUNT_WIDTH'(1);
                    if (front_match) begin
                        qcmd.pop = 1'b1;
                        if (in_range) flags_next[tid_idx] = 1'b0;
                    end
                end else if (op_reg == OP_TRYLOCK) begin
                    status = STAT_BUSY;
                end else if (in_range && flags_reg[tid_idx]) begin
                    status = STAT_WAITING;
                end else if (!in_range || q_full) begin
                    status = STAT_QUEUE_FULL;
                end else begin
                    qcmd.push           = 1'b1;
                    flags_next[tid_idx] = 1'b1;
                    status              = STAT_WAITING;
                end
            end
            OP_UNLOCK: begin
                if (own) begin
                    hold_next = hold_dec;
                    if (hold_dec == '0) begin
                        held_next  = 1'b0;
                        owner_next = '0;
                        if (!q_empty) begin
                            wake_v = 1'b1;
                            wake_t = front_id;
                        end
                    end
                end else begin
                    status = STAT_NOT_OWNER;
                end
            end
            OP_DESTROY: begin
                if (q_empty) begin
                    held_next  = 1'b0;
                    owner_next = '0;
                    hold_next  = '0;
                    qcmd.clear = 1'b1;
                end else begin
                    status = STAT_BUSY;
                end
            end
            default: status = STAT_OK;
        endcase
        // Only commit on the execute cycle
        if (!exec_fire) begin
            qcmd.push  = 1'b0;
            qcmd.pop   = 1'b0;
            qcmd.clear = 1'b0;
        end
    end

    // Hold lock state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= FSM_IDLE;
            held_reg  <= 1'b0;
            owner_reg <= '0;
            hold_reg  <= '0;
            flags_reg <= '0;
        end else begin
            state_reg <= state_next;
            if (exec_fire) begin
                held_reg  <= held_next;
                owner_reg <= owner_next;
                hold_reg  <= hold_next;
                flags_reg <= flags_next;
            end
        end
    end

    // Output register
    always_comb begin
        m_valid_next = m_valid_reg;
        if (exec_fire) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (exec_fire) begin
            m_data_reg <= {3'd0,
                           held_next ? owner_next : 4'd0,
                           held_next,
                           wake_t,
                           wake_v,
                           status};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule

[sv/rfmu_wait_queue.sv]
// Circular waiter queue held in a synchronous memory, with head, tail and fill count.
module rfmu_wait_queue
    import rfmu_pkg::*;
#(
    parameter int THREAD_COUNT = THREAD_COUNT_DEF,
    localparam int PTR_W = $clog2(THREAD_COUNT),
    localparam int CNT_W = $clog2(THREAD_COUNT + 1)
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  queue_cmd_t       cmd,
    output logic [TID_W-1:0] front_id,
    output logic [CNT_W-1:0] count
);

    logic [TID_W-1:0] wait_mem [THREAD_COUNT];
    logic [TID_W-1:0] front_reg;
    logic [PTR_W-1:0] head_reg, head_next;
    logic [PTR_W-1:0] tail_reg, tail_next;
    logic [CNT_W-1:0] count_reg, count_next;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        ptr_inc = (32'(p) == THREAD_COUNT - 1) ? '0 : p + PTR_W'(1);
    endfunction

    // Write the pushed thread at the tail
    always_ff @(posedge aclk) begin
        if (cmd.push) begin
            wait_mem[tail_reg] <= cmd.push_id;
        end
    end

    // Read the front entry every cycle; data lands in front_reg in the next cycle
    always_ff @(posedge aclk) begin
        front_reg <= wait_mem[head_reg];
    end

    // Advance pointers and count
    always_comb begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        if (cmd.clear) begin
            head_next = '0;
            tail_next = '0;
        end else if (cmd.pop) begin
            head_next  = ptr_inc(head_reg);
            count_next = count_reg - CNT_W'(1);
        end else if (cmd.push) begin
            tail_next  = ptr_inc(tail_reg);
            count_next = count_reg + CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end else begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    assign front_id = front_reg;
    assign count    = count_reg;

endmodule

[tb/rfmu_checker.sv]
// Checker for the recursive FIFO mutex unit: predicts each lock result and compares it.
`timescale 1ns / 1ps

module rfmu_checker
    import rfmu_pkg::*;
#(
    parameter int THREAD_COUNT = THREAD_COUNT_DEF,
    parameter int COUNT_WIDTH  = COUNT_WIDTH_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    input  logic                 s_tready,
    // [1:0] operation, [5:2] thread_id, [7:6] zero
    input  logic [S_TDATA_W-1:0] s_tdata,
    input  logic                 m_tvalid,
    input  logic                 m_tready,
    // [2:0] status, [3] wake_valid, [7:4] wake_thread, [8] owner_valid,
    // [12:9] owner_thread, [15:13] zero
    input  logic [M_TDATA_W-1:0] m_tdata,
    output int                   mismatches,
    output int                   outstanding,
    output int                   results_checked,
    output int                   wakeups_seen,
    output int                   overflows_seen
);

    typedef struct {
        status_t          status;
        logic             wake_valid;
        logic [TID_W-1:0] wake_thread;
        logic             owner_valid;
        logic [TID_W-1:0] owner_thread;
    } lock_result_t;

    // Shadow of the lock and its waiter queue
    logic                   lock_held;
    logic [TID_W-1:0]       lock_owner;
    logic [COUNT_WIDTH-1:0] nest_depth;
    logic [TID_W-1:0]       waiter_ring [THREAD_COUNT];
    logic                   is_waiting  [THREAD_COUNT];
    int                     ring_head;
    int                     ring_tail;
    int                     waiter_count;

    lock_result_t expected_results [$];

    function automatic int ring_next(input int ptr);
        return (ptr == THREAD_COUNT - 1) ? 0 : ptr + 1;
    endfunction

    task automatic clear_lock_state();
        lock_held    = 1'b0;
        lock_owner   = '0;
        nest_depth   = '0;
        ring_head    = 0;
        ring_tail    = 0;
        waiter_count = 0;
        for (int i = 0; i < THREAD_COUNT; i++) begin
            is_waiting[i] = 1'b0;
        end
    endtask

    // Apply one request to the shadow state and work out its answer
    task automatic apply_request(input op_t op, input logic [TID_W-1:0] tid,
                                 output lock_result_t res);
        logic granted;
        logic saturated;
        logic has_slot;
        granted        = 1'b0;
        saturated      = 1'b0;
        has_slot       = (int'(tid) < THREAD_COUNT);
        res.status     = STAT_OK;
        res.wake_valid = 1'b0;
        res.wake_thread = '0;

        case (op)
            OP_LOCK, OP_TRYLOCK: begin
                if (lock_held && lock_owner == tid) begin
                    if (nest_depth == '1) begin
                        saturated = 1'b1;
                    end else begin
                        nest_depth = nest_depth + COUNT_WIDTH'(1);
                        granted    = 1'b1;
                    end
                end else if (!lock_held &&
                             (waiter_count == 0 || waiter_ring[ring_head] == tid)) begin
                    // Hand the lock to the front waiter, or to anyone if none wait
                    if (waiter_count != 0) begin
                        ring_head    = ring_next(ring_head);
                        waiter_count = waiter_count - 1;
                        if (has_slot) begin
                            is_waiting[tid] = 1'b0;
                        end
                    end
                    lock_held  = 1'b1;
                    lock_owner = tid;
                    nest_depth = COUNT_WIDTH'(1);
                    granted    = 1'b1;
                end

                if (saturated) begin
                    res.status = STAT_OVERFLOW;
                end else if (!granted) begin
                    if (op == OP_TRYLOCK) begin
                        res.status = STAT_BUSY;
                    end else if (has_slot && is_waiting[tid]) begin
                        res.status = STAT_WAITING;
                    end else if (!has_slot || waiter_count >= THREAD_COUNT) begin
                        res.status = STAT_QUEUE_FULL;
                    end else begin
                        waiter_ring[ring_tail] = tid;
                        ring_tail              = ring_next(ring_tail);
                        waiter_count           = waiter_count + 1;
                        is_waiting[tid]        = 1'b1;
                        res.status             = STAT_WAITING;
                    end
                end
            end
            OP_UNLOCK: begin
                if (lock_held && lock_owner == tid) begin
                    if (nest_depth != '0) begin
                        nest_depth = nest_depth - COUNT_WIDTH'(1);
                    end
                    if (nest_depth == '0) begin
                        lock_held  = 1'b0;
                        lock_owner = '0;
                        if (waiter_count != 0) begin
                            res.wake_valid  = 1'b1;
                            res.wake_thread = waiter_ring[ring_head];
                        end
                    end
                end else begin
                    res.status = STAT_NOT_OWNER;
                end
            end
            default: begin
                // Destroy only succeeds with nobody waiting
                if (waiter_count == 0) begin
                    lock_held  = 1'b0;
                    lock_owner = '0;
                    nest_depth = '0;
                    ring_head  = 0;
                    ring_tail  = 0;
                end else begin
                    res.status = STAT_BUSY;
                end
            end
        endcase

        res.owner_valid  = lock_held;
        res.owner_thread = lock_held ? lock_owner : '0;
    endtask

    function automatic int check_field(input string field, input int want, input int seen);
        if (want != seen) begin
            $error("%s: expected %0d, actual %0d", field, want, seen);
            return 1;
        end
        return 0;
    endfunction

    // Predict on each accepted request, compare on each accepted result
    always @(posedge aclk) begin
        lock_result_t want;
        lock_result_t seen;
        int           bad;
        if (!aresetn) begin
            clear_lock_state();
            expected_results.delete();
            mismatches      <= 0;
            results_checked <= 0;
            wakeups_seen    <= 0;
            overflows_seen  <= 0;
        end else begin
            if (s_tvalid && s_tready) begin
                apply_request(op_t'(s_tdata[1:0]), s_tdata[5:2], want);
                expected_results.push_back(want);
            end
            if (m_tvalid && m_tready) begin
                seen.status       = status_t'(m_tdata[2:0]);
                seen.wake_valid   = m_tdata[3];
                seen.wake_thread  = m_tdata[7:4];
                seen.owner_valid  = m_tdata[8];
                seen.owner_thread = m_tdata[12:9];
                if (expected_results.size() == 0) begin
                    $error("result transaction with no request outstanding: m_tdata %h",
                           m_tdata);
                    mismatches <= mismatches + 1;
                end else begin
                    want = expected_results.pop_front();
                    bad  = check_field("status", want.status, seen.status)
                         + check_field("wake_valid", want.wake_valid, seen.wake_valid)
                         + check_field("wake_thread", want.wake_thread, seen.wake_thread)
                         + check_field("owner_valid", want.owner_valid, seen.owner_valid)
                         + check_field("owner_thread", want.owner_thread,
                                       seen.owner_thread);
                    mismatches      <= mismatches + bad;
                    results_checked <= results_checked + 1;
                    wakeups_seen    <= wakeups_seen + int'(want.wake_valid);
                    overflows_seen  <= overflows_seen + int'(want.status == STAT_OVERFLOW);
                end
            end
        end
        outstanding <= expected_results.size();
    end

endmodule

[tb/testbench.sv]
// Top-level testbench for the recursive FIFO mutex unit: stimulus, back-pressure and verdict.
`timescale 1ns / 1ps

module testbench;
    import rfmu_pkg::*;

    localparam int  NEST_DEPTH     = 30;
    localparam int  PHASE_REQUESTS = 144;
    localparam int  PRESSURE_HOLD  = 300;
    localparam int  CYCLE_LIMIT    = 1_000_000;

    logic                 aclk;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    // [1:0] operation, [5:2] thread_id, [7:6] zero
    logic [S_TDATA_W-1:0] s_tdata;
    logic                 m_tvalid;
    logic                 m_tready;
    // [2:0] status, [3] wake_valid, [7:4] wake_thread, [8] owner_valid,
    // [12:9] owner_thread, [15:13] zero
    logic [M_TDATA_W-1:0] m_tdata;

    int mismatches;
    int outstanding;
    int results_checked;
    int wakeups_seen;
    int overflows_seen;

    // Idling controls for the sender and receiver, the request pool bound and the cycle count
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int pressure_req   = 0;
    int pool_top       = 15;
    int cycle_count    = 0;

    // Hints taken from returned results to steer the random requests
    int               wake_seq    = 0;
    int               wake_served = 0;
    logic [TID_W-1:0] hint_wake_tid = '0;
    logic             hint_owner_v  = 1'b0;
    logic [TID_W-1:0] hint_owner    = '0;

    recursive_fifo_mutex_unit_top i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    rfmu_checker i_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .mismatches      (mismatches),
        .outstanding     (outstanding),
        .results_checked (results_checked),
        .wakeups_seen    (wakeups_seen),
        .overflows_seen  (overflows_seen)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Stop a hung run
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Track woken threads and the current owner from returned results
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (m_tdata[3]) begin
                hint_wake_tid <= m_tdata[7:4];
                wake_seq      <= wake_seq + 1;
            end
            hint_owner_v <= m_tdata[8];
            hint_owner   <= m_tdata[12:9];
        end
    end

    // Drive result back-pressure, with a long hold-off on request
    initial begin
        int hold_left     = 0;
        int pressure_done = 0;
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (pressure_req != pressure_done) begin
                pressure_done = pressure_req;
                hold_left     = PRESSURE_HOLD;
            end
            if (hold_left > 0) begin
                hold_left = hold_left - 1;
                m_tready  = 1'b0;
            end else begin
                m_tready = ($urandom_range(0, 99) >= recv_stall_pct);
            end
        end
    end

    // Offer one request and hold it until accepted
    task automatic send_request(input op_t op, input logic [TID_W-1:0] tid);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid = 1'b0;
            @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tdata  = {2'b00, tid, op};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        @(negedge aclk);
    endtask

    // Choose a random request, favouring woken threads and the current owner
    task automatic pick_request(output op_t op, output logic [TID_W-1:0] tid);
        int roll;
        roll = $urandom_range(0, 99);
        tid  = TID_W'($urandom_range(0, pool_top));
        if (wake_seq != wake_served && roll < 70) begin
            wake_served = wake_seq;
            tid         = hint_wake_tid;
            op          = (roll < 56) ? OP_LOCK : OP_TRYLOCK;
        end else begin
            roll = $urandom_range(0, 99);
            if (roll < 30) begin
                op = OP_LOCK;
            end else if (roll < 42) begin
                op = OP_TRYLOCK;
            end else if (roll < 72) begin
                op = OP_UNLOCK;
                if (hint_owner_v) tid = hint_owner;
            end else if (roll < 82) begin
                op = OP_UNLOCK;
            end else if (roll < 87) begin
                op = OP_DESTROY;
            end else begin
                op = OP_LOCK;
                if (hint_owner_v) tid = hint_owner;
            end
        end
    endtask

    initial begin
        op_t              op;
        logic [TID_W-1:0] tid;
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        repeat (9) @(negedge aclk);
        aresetn = 1'b1;

        // Basic ownership, nesting, queueing and hand-off
        send_request(OP_UNLOCK, 4'd0);
        send_request(OP_DESTROY, 4'd0);
        send_request(OP_TRYLOCK, 4'd15);
        send_request(OP_LOCK, 4'd15);
        send_request(OP_TRYLOCK, 4'd0);
        send_request(OP_LOCK, 4'd0);
        send_request(OP_LOCK, 4'd0);
        send_request(OP_LOCK, 4'd10);
        send_request(OP_DESTROY, 4'd3);
        send_request(OP_UNLOCK, 4'd0);
        send_request(OP_UNLOCK, 4'd15);
        send_request(OP_UNLOCK, 4'd15);
        send_request(OP_LOCK, 4'd10);
        send_request(OP_TRYLOCK, 4'd5);
        send_request(OP_LOCK, 4'd5);
        send_request(OP_TRYLOCK, 4'd0);
        send_request(OP_UNLOCK, 4'd0);
        send_request(OP_LOCK, 4'd10);
        send_request(OP_UNLOCK, 4'd10);
        send_request(OP_LOCK, 4'd5);
        send_request(OP_UNLOCK, 4'd5);
        send_request(OP_DESTROY, 4'd12);

        // Nest a few dozen levels deep, then destroy while held
        for (int i = 0; i < NEST_DEPTH; i++) begin
            send_request(OP_LOCK, 4'd9);
        end
        send_request(OP_LOCK, 4'd9);
        send_request(OP_TRYLOCK, 4'd9);
        send_request(OP_UNLOCK, 4'd9);
        send_request(OP_DESTROY, 4'd9);

        // Fill the waiter queue with every thread and wrap its tail pointer
        send_request(OP_LOCK, 4'd0);
        for (int t = 1; t < 16; t++) begin
            send_request(OP_LOCK, TID_W'(t));
        end
        send_request(OP_UNLOCK, 4'd0);
        send_request(OP_LOCK, 4'd0);
        send_request(OP_LOCK, 4'd7);
        send_request(OP_TRYLOCK, 4'd1);

        // Random requests through the idling phases
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 65; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 65; end
                default: begin send_idle_pct = 32; recv_stall_pct = 32; end
            endcase
            for (int n = 0; n < PHASE_REQUESTS; n++) begin
                if (n % 40 == 0) begin
                    case ($urandom_range(0, 2))
                        0: pool_top = 1;
                        1: pool_top = 3;
                        default: pool_top = 15;
                    endcase
                end
                // Stall the output while requests keep coming
                if (phase == 0 && n == 60) begin
                    pressure_req = pressure_req + 1;
                end
                pick_request(op, tid);
                send_request(op, tid);
            end
        end
        s_tvalid = 1'b0;

        // Drain outstanding results, then allow a few quiet cycles
        while (outstanding != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);

        $display("Checked %0d lock results, including %0d wake-ups and %0d count overflows,",
                 results_checked, wakeups_seen, overflows_seen);
        $display("over a full waiter queue, free-running, idle, stalled and held-off phases.");
        if (mismatches == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

[files.f]
sv/rfmu_pkg.sv
sv/rfmu_wait_queue.sv
sv/recursive_fifo_mutex_unit_top.sv
tb/rfmu_checker.sv
tb/testbench.sv
